/* src/goq_pkg.sv */
// Shared types and constants for the group ordered queue.
// Used by goq_ctrl, goq_datapath and group_ordered_queue; depends on nothing.
package goq_pkg;

    localparam int SEQ_W      = 16;
    localparam int GROUP_ID_W = 8;

    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_SERVE  = 1'b1;

    typedef enum logic [1:0] {
        RES_ACK,
        RES_FULL,
        RES_EMPTY,
        RES_SERVED
    } res_code_t;

    typedef struct packed {
        logic      capture;
        logic      clr_wr;
        logic      arr_rd;
        logic      arr_link;
        logic      arr_splice;
        logic      srv_rd;
        logic      srv_pop;
        logic      srv_dec;
        logic      load_out;
        res_code_t code;
    } goq_cmd_t;

    typedef struct packed {
        logic kind;
        logic ignore;
        logic full;
        logic empty;
        logic in_group;
        logic clr_done;
        logic out_free;
    } goq_status_t;

endpackage

/* src/goq_ctrl.sv */
// Controller state machine of the group ordered queue.
// Depends on goq_pkg; drives the command struct of goq_datapath.
module goq_ctrl
    import goq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  goq_status_t status,
    output goq_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_ARR_LINK,
        ST_ARR_SPLICE,
        ST_SRV_POP,
        ST_SRV_DEC,
        ST_RESP
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    res_code_t code_reg;
    res_code_t code_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        cmd            = '0;
        cmd.code       = code_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.kind == KIND_ARRIVE)
                begin
                    priority if (status.ignore)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.full)
                    begin
                        code_next  = RES_FULL;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cmd.arr_rd = 1'b1;
                        state_next = ST_ARR_LINK;
                    end
                end
                else
                begin
                    if (status.empty)
                    begin
                        code_next  = RES_EMPTY;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        cmd.srv_rd = 1'b1;
                        state_next = ST_SRV_POP;
                    end
                end
            end
            ST_ARR_LINK:
            begin
                cmd.arr_link = 1'b1;
                code_next    = RES_ACK;
                state_next   = status.in_group ? ST_ARR_SPLICE : ST_RESP;
            end
            ST_ARR_SPLICE:
            begin
                cmd.arr_splice = 1'b1;
                state_next     = ST_RESP;
            end
            ST_SRV_POP:
            begin
                cmd.srv_pop = 1'b1;
                state_next  = ST_SRV_DEC;
            end
            ST_SRV_DEC:
            begin
                cmd.srv_dec = 1'b1;
                code_next   = RES_SERVED;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            code_reg  <= RES_ACK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

`ifndef SYNTH
    a_link_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.arr_link |-> $past(cmd.arr_rd))
        else $error("Arrival linked without a group table lookup.");
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srv_pop |-> $past(cmd.srv_rd))
        else $error("Serve popped without reading the head node.");
    a_no_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !cmd.capture)
        else $error("Two transfers accepted back to back.");
`endif

endmodule

/* src/goq_datapath.sv */
// Datapath of the group ordered queue: linked node list, group table, free slot
// queue, counters and the result register. Depends on goq_pkg; run by goq_ctrl.
module goq_datapath
    import goq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int GROUP_BITS  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  goq_cmd_t              cmd,
    output goq_status_t           status,
    input  logic                  kind,
    input  logic [GROUP_ID_W-1:0] group_id,
    input  logic [SEQ_W-1:0]      head_count,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  is_serve,
    output logic [SEQ_W-1:0]      served_number,
    output logic                  empty_flag,
    output logic                  full_flag
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int GW = (GROUP_BITS < GROUP_ID_W) ? GROUP_BITS : GROUP_ID_W;
    localparam int GN = 1 << GW;

    // Node list, free slot queue and per-group table.
    logic [PW-1:0]    node_next_mem [QUEUE_DEPTH];
    logic [SEQ_W-1:0] node_num_mem  [QUEUE_DEPTH];
    logic [GW-1:0]    node_grp_mem  [QUEUE_DEPTH];
    logic [PW-1:0]    free_mem      [QUEUE_DEPTH];
    logic [CW-1:0]    grp_cnt_mem   [GN];
    logic [PW-1:0]    grp_tail_mem  [GN];

    logic [PW-1:0]    next_q;
    logic [SEQ_W-1:0] num_q;
    logic [GW-1:0]    grp_q;
    logic [PW-1:0]    free_q;
    logic [CW-1:0]    cnt_q;
    logic [PW-1:0]    tail_q;

    logic [CW-1:0]    occ_reg;
    logic [SEQ_W-1:0] arr_cnt_reg;
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    tail_reg;
    logic [CW-1:0]    fresh_reg;
    logic [PW-1:0]    fifo_rd_reg;
    logic [PW-1:0]    fifo_wr_reg;
    logic [GW-1:0]    clr_reg;
    logic             kind_reg;
    logic [GW-1:0]    g_reg;
    logic [PW-1:0]    slot_reg;

    logic             out_valid_reg;
    logic             is_serve_reg;
    logic [SEQ_W-1:0] served_reg;
    logic             empty_reg;
    logic             full_reg;

    logic             fresh_left;
    logic [PW-1:0]    slot_new;

    logic             next_re;
    logic [PW-1:0]    next_ra;
    logic             next_we;
    logic [PW-1:0]    next_wa;
    logic [PW-1:0]    next_wd;

    logic             grp_re;
    logic [GW-1:0]    grp_ra;
    logic             grp_we;
    logic [GW-1:0]    grp_wa;
    logic [CW-1:0]    grp_cnt_wd;
    logic [PW-1:0]    grp_tail_wd;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign fresh_left = (fresh_reg != CW'(QUEUE_DEPTH));
    assign slot_new   = fresh_left ? fresh_reg[PW-1:0] : free_q;

    always_comb
    begin
        next_re = cmd.arr_link || cmd.srv_rd;
        next_ra = cmd.arr_link ? tail_q : head_reg;
        next_we = 1'b0;
        next_wa = tail_reg;
        next_wd = slot_new;
        if (cmd.arr_link)
        begin
            if (status.in_group)
            begin
                next_we = 1'b1;
                next_wa = tail_q;
            end
            else if (occ_reg != '0)
            begin
                next_we = 1'b1;
                next_wa = tail_reg;
            end
        end
        else if (cmd.arr_splice)
        begin
            next_we = 1'b1;
            next_wa = slot_reg;
            next_wd = next_q;
        end
    end

    always_comb
    begin
        grp_re      = cmd.arr_rd || cmd.srv_pop;
        grp_ra      = cmd.arr_rd ? g_reg : grp_q;
        grp_we      = cmd.clr_wr || cmd.arr_link || cmd.srv_dec;
        grp_wa      = clr_reg;
        grp_cnt_wd  = '0;
        grp_tail_wd = '0;
        if (cmd.arr_link)
        begin
            grp_wa      = g_reg;
            grp_cnt_wd  = cnt_q + CW'(1);
            grp_tail_wd = slot_new;
        end
        else if (cmd.srv_dec)
        begin
            grp_wa      = grp_q;
            grp_cnt_wd  = cnt_q - CW'(1);
            grp_tail_wd = tail_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_re)
        begin
            next_q <= node_next_mem[next_ra];
        end
        if (next_we)
        begin
            node_next_mem[next_wa] <= next_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.srv_rd)
        begin
            num_q <= node_num_mem[head_reg];
            grp_q <= node_grp_mem[head_reg];
        end
        if (cmd.arr_link)
        begin
            node_num_mem[slot_new] <= arr_cnt_reg + SEQ_W'(1);
            node_grp_mem[slot_new] <= g_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arr_rd)
        begin
            free_q <= free_mem[fifo_rd_reg];
        end
        if (cmd.srv_pop)
        begin
            free_mem[fifo_wr_reg] <= head_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_re)
        begin
            cnt_q  <= grp_cnt_mem[grp_ra];
            tail_q <= grp_tail_mem[grp_ra];
        end
        if (grp_we)
        begin
            grp_cnt_mem[grp_wa]  <= grp_cnt_wd;
            grp_tail_mem[grp_wa] <= grp_tail_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            g_reg    <= group_id[GW-1:0];
        end
        if (cmd.arr_link)
        begin
            slot_reg <= slot_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            arr_cnt_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            fresh_reg   <= '0;
            fifo_rd_reg <= '0;
            fifo_wr_reg <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + GW'(1);
            end
            if (cmd.arr_link)
            begin
                occ_reg     <= occ_reg + CW'(1);
                arr_cnt_reg <= arr_cnt_reg + SEQ_W'(1);
                if (fresh_left)
                begin
                    fresh_reg <= fresh_reg + CW'(1);
                end
                else
                begin
                    fifo_rd_reg <= ptr_inc(fifo_rd_reg);
                end
                if (!status.in_group)
                begin
                    tail_reg <= slot_new;
                    if (occ_reg == '0)
                    begin
                        head_reg <= slot_new;
                    end
                end
                else if (tail_q == tail_reg)
                begin
                    tail_reg <= slot_new;
                end
            end
            if (cmd.srv_pop)
            begin
                occ_reg     <= occ_reg - CW'(1);
                head_reg    <= next_q;
                fifo_wr_reg <= ptr_inc(fifo_wr_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            is_serve_reg <= (cmd.code == RES_EMPTY) || (cmd.code == RES_SERVED);
            served_reg   <= (cmd.code == RES_SERVED) ? num_q : '0;
            empty_reg    <= (cmd.code == RES_EMPTY);
            full_reg     <= (cmd.code == RES_FULL);
        end
    end

    assign status.kind     = kind_reg;
    assign status.ignore   = (arr_cnt_reg >= head_count);
    assign status.full     = (occ_reg == CW'(QUEUE_DEPTH));
    assign status.empty    = (occ_reg == '0);
    assign status.in_group = (cnt_q != '0);
    assign status.clr_done = (clr_reg == GW'(GN - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign is_serve      = is_serve_reg;
    assign served_number = served_reg;
    assign empty_flag    = empty_reg;
    assign full_flag     = full_reg;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(QUEUE_DEPTH))
        else $error("Occupancy exceeds the queue depth.");
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srv_pop |-> (occ_reg != '0))
        else $error("Serve popped an empty queue.");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srv_pop |=> (occ_reg == $past(occ_reg) - CW'(1)))
        else $error("Occupancy did not drop after a serve.");
    a_link_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.arr_link |-> !status.full)
        else $error("Arrival linked into a full store.");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("Result register overwritten before its transfer.");
`endif

endmodule

/* src/group_ordered_queue.sv */
// Group ordered queue. An arrival that is taken passes the check and link steps, and the
// splice step as well when it is placed behind its group rather than appended at the tail;
// a serve passes the check, pop and decrement steps; a refused arrival or empty serve goes
// from the check straight to the result. An arrival past head_count gives no result. A new
// item is taken only once the last result is loaded into the free result register. After
// reset a clearing pass sweeps the group table, with in_ready low; head_count resets to zero.
module group_ordered_queue
    import goq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int GROUP_BITS  = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [GROUP_ID_W-1:0] group_id,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_serve,
    output logic [SEQ_W-1:0]      served_number,
    output logic                  empty_flag,
    output logic                  full_flag,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SEQ_W-1:0]      head_count
);

    logic [SEQ_W-1:0] head_count_reg;
    goq_cmd_t         cmd;
    goq_status_t      status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            head_count_reg <= head_count;
        end
    end

    goq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    goq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .GROUP_BITS  (GROUP_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (kind),
        .group_id      (group_id),
        .head_count    (head_count_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .is_serve      (is_serve),
        .served_number (served_number),
        .empty_flag    (empty_flag),
        .full_flag     (full_flag)
    );

endmodule

/* bench/group_ordered_queue_test.sv */
// Self-checking bench for group_ordered_queue: a team-queue tracker predicts every result
// from the accepted transfers and compares each returned result with it field by field.
// Depends on goq_pkg and group_ordered_queue.
module group_ordered_queue_test;
    import goq_pkg::*;

    localparam int LINE_DEPTH    = 256;
    localparam int GROUP_WIDTH   = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 240;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [GROUP_ID_W-1:0] group;
        logic [SEQ_W-1:0]      number;
    } waiting_person_t;

    typedef struct {
        logic             is_serve;
        logic [SEQ_W-1:0] number;
        logic             empty;
        logic             full;
    } queue_result_t;

    class team_line_tracker;
        waiting_person_t  line[$];
        queue_result_t    owed[$];
        logic [SEQ_W-1:0] limit;
        logic [SEQ_W-1:0] arrivals;
        int               mismatches;
        int               joined;
        int               refused;
        int               served;
        int               empty_serves;
        int               ignored;

        function new();
            limit        = '0;
            arrivals     = '0;
            mismatches   = 0;
            joined       = 0;
            refused      = 0;
            served       = 0;
            empty_serves = 0;
            ignored      = 0;
        endfunction

        function void take_request(logic k, logic [GROUP_ID_W-1:0] g);
            queue_result_t   res;
            waiting_person_t person;
            int              pos;
            res.is_serve = k;
            res.number   = '0;
            res.empty    = 1'b0;
            res.full     = 1'b0;
            if (k == KIND_ARRIVE)
            begin
                if (arrivals >= limit)
                begin
                    ignored++;
                    return;
                end
                if (line.size() >= LINE_DEPTH)
                begin
                    res.full = 1'b1;
                    refused++;
                end
                else
                begin
                    pos = line.size();
                    for (int j = 0; j < line.size(); j++)
                    begin
                        if (line[j].group == g &&
                            (j + 1 >= line.size() || line[j + 1].group != g))
                        begin
                            pos = j + 1;
                            break;
                        end
                    end
                    arrivals      = arrivals + 1'b1;
                    person.group  = g;
                    person.number = arrivals;
                    line.insert(pos, person);
                    joined++;
                end
            end
            else if (line.size() == 0)
            begin
                res.empty = 1'b1;
                empty_serves++;
            end
            else
            begin
                res.number = line[0].number;
                void'(line.pop_front());
                served++;
            end
            owed.push_back(res);
        endfunction

        function void flag(string what, queue_result_t want, queue_result_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display({"%0t: %s: expected serve=%0d number=%0d empty=%0d full=%0d, ",
                          "got serve=%0d number=%0d empty=%0d full=%0d"},
                         $time, what, want.is_serve, want.number, want.empty, want.full,
                         got.is_serve, got.number, got.empty, got.full);
        endfunction

        function void match_result(queue_result_t got);
            queue_result_t want;
            if (owed.size() == 0)
            begin
                flag("result with nothing outstanding", got, got);
                return;
            end
            want = owed.pop_front();
            if (got.is_serve !== want.is_serve || got.number !== want.number ||
                got.empty !== want.empty || got.full !== want.full)
                flag("wrong result", want, got);
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  kind       = KIND_ARRIVE;
    logic [GROUP_ID_W-1:0] group_id   = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic                  is_serve;
    logic [SEQ_W-1:0]      served_number;
    logic                  empty_flag;
    logic                  full_flag;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [SEQ_W-1:0]      head_count = '0;

    team_line_tracker tracker = new();
    bit               send_steady  = 1'b0;
    bit               recv_steady  = 1'b0;
    int               hold_request = 0;

    group_ordered_queue #(
        .QUEUE_DEPTH (LINE_DEPTH),
        .GROUP_BITS  (GROUP_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .group_id      (group_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_serve      (is_serve),
        .served_number (served_number),
        .empty_flag    (empty_flag),
        .full_flag     (full_flag),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .head_count    (head_count)
    );

    always #5 clk = ~clk;

    task automatic send_item(input logic k, input logic [GROUP_ID_W-1:0] g);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        group_id <= g;
        do @(posedge clk); while (!in_ready);
        tracker.take_request(k, g);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.owed.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_head_count(input logic [SEQ_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid  <= 1'b1;
        head_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        tracker.limit = value;
    endtask

    initial
    begin : result_sink
        int            stall;
        queue_result_t got;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = recv_steady ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (out_valid)
                    break;
                if (hold_request > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (hold_request) @(posedge clk);
                    hold_request = 0;
                    out_ready <= 1'b1;
                end
            end
            got.is_serve = is_serve;
            got.number   = served_number;
            got.empty    = empty_flag;
            got.full     = full_flag;
            tracker.match_result(got);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("group_ordered_queue: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int                    before_ignored;
        int                    counted;
        int                    sent;
        int                    serve_pct;
        logic                  k;
        logic [GROUP_ID_W-1:0] g;
        logic [SEQ_W-1:0]      limit_value;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_head_count('0);
        send_item(KIND_ARRIVE, 8'h00);
        send_item(KIND_ARRIVE, 8'hFF);
        send_item(KIND_SERVE, 8'hFF);

        write_head_count('1);
        send_item(KIND_SERVE, 8'h00);
        send_item(KIND_ARRIVE, 8'h03);
        send_item(KIND_ARRIVE, 8'h07);
        send_item(KIND_ARRIVE, 8'h03);
        send_item(KIND_ARRIVE, 8'h00);
        send_item(KIND_ARRIVE, 8'hFF);
        send_item(KIND_ARRIVE, 8'h07);
        wait_drained();
        send_item(KIND_ARRIVE, 8'hAA);
        send_item(KIND_ARRIVE, 8'h55);
        send_item(KIND_ARRIVE, 8'hFF);
        repeat (10) send_item(KIND_SERVE, GROUP_ID_W'($urandom_range(0, 255)));

        // The line is filled past its capacity, with the receiver holding off at the start.
        wait_drained();
        hold_request = LONG_HOLD;
        repeat (LINE_DEPTH + 4) send_item(KIND_ARRIVE, GROUP_ID_W'($urandom_range(0, 15)));
        repeat (LINE_DEPTH + 2) send_item(KIND_SERVE, GROUP_ID_W'($urandom_range(0, 255)));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: limit_value = tracker.arrivals + 16'd40;
                1: limit_value = SEQ_W'($urandom_range(0, 65535));
                2: limit_value = tracker.arrivals + 16'd200;
                default: limit_value = '1;
            endcase
            write_head_count(limit_value);
            send_steady = (phase == 1);
            recv_steady = (phase == 2);
            serve_pct   = 35 + 10 * phase;
            counted     = 0;
            sent        = 0;
            while (counted < PHASE_ITEMS && sent < 2 * PHASE_ITEMS)
            begin
                k = ($urandom_range(0, 99) < serve_pct) ? KIND_SERVE : KIND_ARRIVE;
                g = ($urandom_range(0, 4) == 0) ? GROUP_ID_W'($urandom_range(0, 255))
                                                : GROUP_ID_W'($urandom_range(0, 7));
                before_ignored = tracker.ignored;
                send_item(k, g);
                if (tracker.ignored == before_ignored)
                    counted++;
                sent++;
                if (phase == 3 && sent == PHASE_ITEMS / 2)
                    wait_drained();
            end
        end
        send_steady = 1'b0;
        recv_steady = 1'b0;

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d joins, %0d refusals on a full line, %0d serves, %0d empty serves",
                 tracker.joined, tracker.refused, tracker.served, tracker.empty_serves);
        $display("and %0d arrivals past the head count, with %0d mismatched results.",
                 tracker.ignored, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.owed.size() == 0)
            $display("group_ordered_queue: match");
        else
            $display("group_ordered_queue: mismatch");
        $finish;
    end

endmodule
